@@ sv/bst_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

    localparam int BST_WAYS           = 4;
    localparam int BST_MAX_INDEX_BITS = 10;

    localparam int CMD_W   = 2;
    localparam int KEY_W   = 32;
    localparam int SCORE_W = 32;
    localparam int USED_W  = 13;
    localparam int IB_W    = 4;

    localparam logic [IB_W-1:0]   IB_RESET = IB_W'(10);
    localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic rd;
        logic eval;
        logic scan;
        logic wr;
        logic clr;
        logic finish;
    } bst_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_scan;
        logic scan_last;
        logic clr_last;
    } bst_stat_t;

endpackage

`default_nettype wire

@@ sv/bst_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bst_ctrl
    import bst_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [CMD_W-1:0] command,
    input  wire bst_stat_t        stat,
    output bst_cmd_t              cmd,
    output logic                  busy
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_EVAL  = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_CLEAR = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   report_reg, report_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // sweep the store after reset without reporting
            state_reg  <= ST_CLEAR;
            report_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            report_reg <= report_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        report_next = report_reg;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    if (cmd_t'(command) == CMD_CLEAR)
                    begin
                        state_next  = ST_CLEAR;
                        report_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.need_scan ? ST_SCAN : ST_WRITE;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr     = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    cmd.finish  = report_reg;
                    report_next = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

@@ sv/bst_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bst_dpath
    import bst_pkg::*;
#(
    parameter int WAYS           = BST_WAYS,
    parameter int MAX_INDEX_BITS = BST_MAX_INDEX_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bst_cmd_t                  cmd,
    output bst_stat_t                      stat,
    input  wire logic [CMD_W-1:0]          command,
    input  wire logic [KEY_W-1:0]          key,
    input  wire logic signed [SCORE_W-1:0] score,
    input  wire logic                      index_bits_we,
    input  wire logic [IB_W-1:0]           index_bits_wdata,
    output logic                           done,
    output logic                           ok,
    output logic signed [SCORE_W-1:0]      found_score,
    output logic [USED_W-1:0]              used_ways
);

    localparam int AW    = MAX_INDEX_BITS;
    localparam int ROWS  = 1 << AW;
    localparam int DEPTH = ROWS * WAYS;
    localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SAT_W = (CNT_W > USED_W) ? CNT_W : USED_W;

    // one row holds all ways of a bucket
    logic [WAYS*KEY_W-1:0]   key_mem   [ROWS];
    logic [WAYS*SCORE_W-1:0] score_mem [ROWS];

    logic [IB_W-1:0]           ib_reg;
    logic [IB_W-1:0]           ib_eff;
    logic [AW-1:0]             row_mask;
    cmd_t                      cmd_reg;
    logic [KEY_W-1:0]          key_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [AW-1:0]             row_addr_reg;
    logic [WAYS*KEY_W-1:0]     key_row_reg;
    logic [WAYS*SCORE_W-1:0]   score_row_reg;
    logic                      hit_reg;
    logic                      empty_any_reg;
    logic [WAYS-1:0]           tgt_oh_reg;
    logic signed [SCORE_W-1:0] cmp_score_reg;
    logic [WW-1:0]             scan_idx_reg;
    logic [AW-1:0]             clr_addr_reg;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      done_reg;
    logic                      ok_reg;
    logic signed [SCORE_W-1:0] fs_reg;
    logic [USED_W-1:0]         used_reg;

    logic [WAYS-1:0]           match_vec, empty_vec, match_first, empty_first;
    logic signed [SCORE_W-1:0] match_score;
    logic signed [SCORE_W-1:0] scan_score;
    logic                      lt;
    logic                      ok_val;
    logic                      do_write;
    logic [KEY_W-1:0]          old_key;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [WAYS*KEY_W-1:0]     key_wrow;
    logic [WAYS*SCORE_W-1:0]   score_wrow;
    logic [SAT_W-1:0]          cnt_wide;

    // index_bits above the table size acts as the table size
    always_comb
    begin
        if (int'(ib_reg) > MAX_INDEX_BITS)
            ib_eff = IB_W'(MAX_INDEX_BITS);
        else
            ib_eff = ib_reg;
        row_mask = ~({AW{1'b1}} << ib_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ib_reg <= IB_RESET;
        else if (index_bits_we)
            ib_reg <= index_bits_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            cmd_reg      <= cmd_t'(command);
            key_reg      <= key;
            score_reg    <= score;
            row_addr_reg <= key[AW-1:0] & row_mask;
        end
    end

    // bucket compare across ways
    always_comb
    begin
        match_score = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            match_vec[w] = (key_row_reg[w*KEY_W +: KEY_W] == key_reg);
            empty_vec[w] = (key_row_reg[w*KEY_W +: KEY_W] == '0) &&
                           (score_row_reg[w*SCORE_W +: SCORE_W] == '0);
        end
        match_first = match_vec & (~match_vec + WAYS'(1));
        empty_first = empty_vec & (~empty_vec + WAYS'(1));
        for (int w = 0; w < WAYS; w++)
        begin
            if (match_first[w])
                match_score = match_score | score_row_reg[w*SCORE_W +: SCORE_W];
        end
    end

    assign scan_score = score_row_reg[scan_idx_reg*SCORE_W +: SCORE_W];

    assign stat.need_scan = (WAYS > 1) && (cmd_reg == CMD_INSERT) &&
                            !(|match_vec) && !(|empty_vec);
    assign stat.scan_last = (scan_idx_reg == WW'(WAYS - 1));
    assign stat.clr_last  = (clr_addr_reg == AW'(ROWS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            hit_reg       <= |match_vec;
            empty_any_reg <= |empty_vec;
            scan_idx_reg  <= WW'(1);
            if (|match_vec)
            begin
                tgt_oh_reg    <= match_first;
                cmp_score_reg <= match_score;
            end
            else
            begin
                tgt_oh_reg    <= (|empty_vec) ? empty_first : WAYS'(1);
                cmp_score_reg <= score_row_reg[SCORE_W-1:0];
            end
        end
        else if (cmd.scan)
        begin
            // keep the first way with the smallest score
            if (scan_score < cmp_score_reg)
            begin
                cmp_score_reg <= scan_score;
                tgt_oh_reg    <= WAYS'(1) << scan_idx_reg;
            end
            scan_idx_reg <= scan_idx_reg + WW'(1);
        end
    end

    assign lt = (cmp_score_reg < score_reg);

    always_comb
    begin
        case (cmd_reg)
            CMD_INSERT: ok_val = hit_reg ? lt : (empty_any_reg || lt);
            CMD_LOOKUP: ok_val = hit_reg;
            CMD_CHECK:  ok_val = !hit_reg || lt;
            default:    ok_val = 1'b1;
        endcase
    end

    assign do_write = (cmd_reg == CMD_INSERT) && ok_val;

    always_comb
    begin
        old_key = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (tgt_oh_reg[w])
            begin
                key_wrow[w*KEY_W +: KEY_W]       = key_reg;
                score_wrow[w*SCORE_W +: SCORE_W] = score_reg;
                old_key = old_key | key_row_reg[w*KEY_W +: KEY_W];
            end
            else
            begin
                key_wrow[w*KEY_W +: KEY_W]       = key_row_reg[w*KEY_W +: KEY_W];
                score_wrow[w*SCORE_W +: SCORE_W] = score_row_reg[w*SCORE_W +: SCORE_W];
            end
        end
    end

    assign mem_we    = cmd.clr || (cmd.wr && do_write);
    assign mem_waddr = cmd.clr ? clr_addr_reg : row_addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            key_row_reg   <= key_mem[row_addr_reg];
            score_row_reg <= score_mem[row_addr_reg];
        end
        if (mem_we)
        begin
            key_mem[mem_waddr]   <= cmd.clr ? '0 : key_wrow;
            score_mem[mem_waddr] <= cmd.clr ? '0 : score_wrow;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.clr)
            cnt_next = '0;
        else if (cmd.wr && do_write)
        begin
            if ((old_key == '0) && (key_reg != '0))
                cnt_next = cnt_reg + CNT_W'(1);
            else if ((old_key != '0) && (key_reg == '0) && (cnt_reg != '0))
                cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    assign cnt_wide = SAT_W'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            cnt_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= cmd.finish;
            if (cmd.clr)
                clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            ok_reg   <= ok_val;
            fs_reg   <= ((cmd_reg == CMD_LOOKUP) && hit_reg) ? cmp_score_reg : '0;
            used_reg <= (cnt_wide > SAT_W'(USED_MAX)) ? USED_MAX : USED_W'(cnt_wide);
        end
    end

    assign done        = done_reg;
    assign ok          = ok_reg;
    assign found_score = fs_reg;
    assign used_ways   = used_reg;

endmodule

`default_nettype wire

@@ sv/bucketed_score_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Words / fields
// -------   ---------------------  ---------------------------------------
// command   start, busy            command[1:0], key[31:0], score[31:0]
// result    done (1-cycle strobe)  ok, found_score[31:0], used_ways[12:0]
// config    index_bits_we          index_bits_wdata[3:0]
//
// A word is taken when start is high and busy is low. Lookup, check and an
// insert that hits or finds an empty way pass through accept, bucket read,
// compare and write back; an insert that misses on a full bucket also scans
// the remaining ways for the smallest score first. Clear writes one row a
// cycle, over all 2**MAX_INDEX_BITS rows. Reset starts a sweep of all rows
// with busy high. The receiver cannot stall.

module bucketed_score_table_core
    import bst_pkg::*;
#(
    parameter int WAYS           = BST_WAYS,
    parameter int MAX_INDEX_BITS = BST_MAX_INDEX_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [CMD_W-1:0]          command,
    input  wire logic [KEY_W-1:0]          key,
    input  wire logic signed [SCORE_W-1:0] score,
    input  wire logic                      index_bits_we,
    input  wire logic [IB_W-1:0]           index_bits_wdata,
    output logic                           done,
    output logic                           ok,
    output logic signed [SCORE_W-1:0]      found_score,
    output logic [USED_W-1:0]              used_ways
);

    bst_cmd_t  cmd;
    bst_stat_t stat;

    // sequencer: walks read, compare, scan, write back and clear sweeps
    bst_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    // bucket store, way compare, replacement choice and used-way counter
    bst_dpath #(
        .WAYS           (WAYS),
        .MAX_INDEX_BITS (MAX_INDEX_BITS)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .command          (command),
        .key              (key),
        .score            (score),
        .index_bits_we    (index_bits_we),
        .index_bits_wdata (index_bits_wdata),
        .done             (done),
        .ok               (ok),
        .found_score      (found_score),
        .used_ways        (used_ways)
    );

endmodule

`default_nettype wire

@@ sv/bst_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bst_checker
    import bst_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      done,
    input wire logic                      ok,
    input wire logic signed [SCORE_W-1:0] found_score
);

    // a result always leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // an accepted word holds the block busy next cycle, with no result yet
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not start work");

    // strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // a score comes back only with a hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (found_score == '0))
        else $error("score reported without a hit");

endmodule

bind bucketed_score_table_core bst_checker u_bst_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .ok          (ok),
    .found_score (found_score)
);

`default_nettype wire

@@ tb/score_table_checker.sv @@
`timescale 1ns / 1ps

module score_table_checker
    import bst_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire logic [CMD_W-1:0]          command,
    input  wire logic [KEY_W-1:0]          key,
    input  wire logic signed [SCORE_W-1:0] score,
    input  wire logic                      index_bits_we,
    input  wire logic [IB_W-1:0]           index_bits_wdata,
    input  wire logic                      done,
    input  wire logic                      ok,
    input  wire logic signed [SCORE_W-1:0] found_score,
    input  wire logic [USED_W-1:0]         used_ways,
    output int                             pending,
    output int                             fails
);

    localparam int ENTRIES = BST_WAYS << BST_MAX_INDEX_BITS;

    typedef struct packed {
        logic                      ok;
        logic signed [SCORE_W-1:0] found;
        logic [USED_W-1:0]         used;
    } reply_t;

    logic [KEY_W-1:0]          key_mirror [ENTRIES];
    logic signed [SCORE_W-1:0] score_mirror [ENTRIES];
    int unsigned               live_ways;
    logic [IB_W-1:0]           bucket_bits;
    reply_t                    expected_replies [$];
    int                        mismatches = 0;

    function automatic void wipe_table();
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_mirror[i]   = '0;
            score_mirror[i] = '0;
        end
        live_ways = 0;
    endfunction

    // keep the occupancy count in step with every way that is written
    function automatic void write_way(int unsigned idx, logic [KEY_W-1:0] k,
                                      logic signed [SCORE_W-1:0] s);
        if (key_mirror[idx] == '0 && k != '0)
            live_ways++;
        else if (key_mirror[idx] != '0 && k == '0 && live_ways > 0)
            live_ways--;
        key_mirror[idx]   = k;
        score_mirror[idx] = s;
    endfunction

    function automatic reply_t apply_table_command(cmd_t op, logic [KEY_W-1:0] k,
                                                   logic signed [SCORE_W-1:0] s);
        reply_t           r;
        int unsigned      span;
        int unsigned      base;
        int unsigned      lo;
        logic [KEY_W-1:0] mask;
        int               hit;
        logic             placed;
        r    = '0;
        span = (bucket_bits > BST_MAX_INDEX_BITS) ? BST_MAX_INDEX_BITS : bucket_bits;
        mask = (KEY_W'(1) << span) - KEY_W'(1);
        base = (k & mask) * BST_WAYS;
        hit  = -1;
        for (int w = BST_WAYS - 1; w >= 0; w--)
            if (key_mirror[base + w] == k)
                hit = w;
        case (op)
            CMD_INSERT:
            begin
                if (hit >= 0)
                begin
                    if (score_mirror[base + hit] < s)
                    begin
                        write_way(base + hit, k, s);
                        r.ok = 1'b1;
                    end
                end
                else
                begin
                    placed = 1'b0;
                    for (int w = 0; w < BST_WAYS && !placed; w++)
                        if (key_mirror[base + w] == '0 && score_mirror[base + w] == 0)
                        begin
                            write_way(base + w, k, s);
                            placed = 1'b1;
                        end
                    if (!placed)
                    begin
                        lo = 0;
                        for (int w = 1; w < BST_WAYS; w++)
                            if (score_mirror[base + w] < score_mirror[base + lo])
                                lo = w;
                        if (score_mirror[base + lo] < s)
                        begin
                            write_way(base + lo, k, s);
                            placed = 1'b1;
                        end
                    end
                    r.ok = placed;
                end
            end
            CMD_LOOKUP:
            begin
                if (hit >= 0)
                begin
                    r.ok    = 1'b1;
                    r.found = score_mirror[base + hit];
                end
            end
            CMD_CHECK:
                r.ok = (hit < 0) || (score_mirror[base + hit] < s);
            default:
            begin
                wipe_table();
                r.ok = 1'b1;
            end
        endcase
        r.used = (live_ways > USED_MAX) ? USED_MAX : USED_W'(live_ways);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n)
        begin
            wipe_table();
            bucket_bits = IB_RESET;
            expected_replies.delete();
            pending <= 0;
        end
        else
        begin
            // retire the oldest expectation before queuing a word taken on this edge
            if (done)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("result word with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (ok !== want.ok)
                    begin
                        $error("ok: expected %0d, actual %0d", want.ok, ok);
                        mismatches++;
                    end
                    if (found_score !== want.found)
                    begin
                        $error("found_score: expected %0d, actual %0d",
                               $signed(want.found), found_score);
                        mismatches++;
                    end
                    if (used_ways !== want.used)
                    begin
                        $error("used_ways: expected %0d, actual %0d", want.used, used_ways);
                        mismatches++;
                    end
                end
            end
            if (index_bits_we)
                bucket_bits = index_bits_wdata;
            if (start && !busy)
                expected_replies.push_back(apply_table_command(cmd_t'(command), key, score));
            pending <= expected_replies.size();
        end
        fails <= mismatches;
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import bst_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [CMD_W-1:0]          command;
    logic [KEY_W-1:0]          key;
    logic signed [SCORE_W-1:0] score;
    logic                      index_bits_we;
    logic [IB_W-1:0]           index_bits_wdata;
    logic                      done;
    logic                      ok;
    logic signed [SCORE_W-1:0] found_score;
    logic [USED_W-1:0]         used_ways;

    int   pending;
    int   fails;

    // set while the sender should push words back to back with no gaps
    logic no_gaps;

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    bucketed_score_table_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .key              (key),
        .score            (score),
        .index_bits_we    (index_bits_we),
        .index_bits_wdata (index_bits_wdata),
        .done             (done),
        .ok               (ok),
        .found_score      (found_score),
        .used_ways        (used_ways)
    );

    score_table_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .command          (command),
        .key              (key),
        .score            (score),
        .index_bits_we    (index_bits_we),
        .index_bits_wdata (index_bits_wdata),
        .done             (done),
        .ok               (ok),
        .found_score      (found_score),
        .used_ways        (used_ways),
        .pending          (pending),
        .fails            (fails)
    );

    // Present one command word and hold it until the block takes it.
    // Before raising start, idle for a random number of cycles (about 37 in
    // a hundred) unless the current stretch runs with no gaps. The task
    // returns on the edge that accepted the word, with start still high, so
    // a following word can ride straight on without a drop in start.
    task automatic send_word(cmd_t op, logic [KEY_W-1:0] k, logic signed [SCORE_W-1:0] s);
        while (!no_gaps && $urandom_range(0, 99) < 37)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        command <= op;
        key     <= k;
        score   <= s;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Write index_bits only once the block is idle: drop start, let the checker
    // count the word just accepted as outstanding, then hold until every result
    // is in and busy is low.
    task automatic set_index_bits(logic [IB_W-1:0] v);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        index_bits_we    <= 1'b1;
        index_bits_wdata <= v;
        @(posedge clk);
        index_bits_we    <= 1'b0;
    endtask

    initial
    begin
        // settings per random phase: both extremes, oversized values and the
        // small bucket counts that force heavy collisions
        logic [IB_W-1:0]           phase_bits [9];
        logic [KEY_W-1:0]          key_pool [16];
        logic [KEY_W-1:0]          last_key;
        logic [KEY_W-1:0]          k;
        logic signed [SCORE_W-1:0] s;
        cmd_t                      op;
        int                        r;

        phase_bits = '{4'd0, 4'd15, 4'd1, 4'd2, 4'd10, 4'd3, 4'd11, 4'd6, 4'd4};

        // drive every input to a known value from time zero
        rst_n            <= 1'b0;
        start            <= 1'b0;
        command          <= CMD_LOOKUP;
        key              <= '0;
        score            <= '0;
        index_bits_we    <= 1'b0;
        index_bits_wdata <= '0;
        no_gaps           = 1'b0;
        last_key          = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset setting (1024 buckets). Keys A..E below
        // all land in bucket 5, so the sequence walks a single bucket through
        // fill, hit, refused update, full bucket and replacement.
        send_word(CMD_LOOKUP, 32'h0000_0000, 32'sd0);        // key zero hits an empty way
        send_word(CMD_CHECK,  32'h0000_0405, 32'sd0);        // miss on an empty bucket
        send_word(CMD_INSERT, 32'h0000_0405, -32'sd5);       // negative score fills an empty way
        send_word(CMD_INSERT, 32'h0000_0405, -32'sd10);      // lower score is refused
        send_word(CMD_CHECK,  32'h0000_0405, -32'sd5);       // equal score is not an improvement
        send_word(CMD_CHECK,  32'h0000_0405, -32'sd4);
        send_word(CMD_INSERT, 32'h0000_0405, 32'sd100);      // raise a stored score
        send_word(CMD_INSERT, 32'h0000_0805, 32'sh8000_0000);
        send_word(CMD_INSERT, 32'h0000_0C05, 32'sd7);
        send_word(CMD_INSERT, 32'h1000_0005, 32'sd0);        // bucket now full
        send_word(CMD_LOOKUP, 32'h1000_0005, 32'sd0);
        send_word(CMD_INSERT, 32'hFFFF_FC05, 32'sh8000_0000); // smallest is not below: refused
        send_word(CMD_CHECK,  32'hFFFF_FC05, 32'sd5);        // full bucket still answers on a miss
        send_word(CMD_INSERT, 32'hFFFF_FC05, 32'sd5);        // evict the smallest score
        send_word(CMD_LOOKUP, 32'h0000_0805, 32'sd0);        // evicted key is gone
        send_word(CMD_INSERT, 32'h0000_0000, 32'sh7FFF_FFFF); // key zero updates in place
        send_word(CMD_LOOKUP, 32'h0000_0000, 32'sd0);
        send_word(CMD_INSERT, 32'hFFFF_FFFF, 32'sh7FFF_FFFF); // top bucket, extreme fields
        send_word(CMD_INSERT, 32'h0000_0000, 32'sd3);
        send_word(CMD_CHECK,  32'hFFFF_FFFF, 32'sh8000_0000);
        send_word(CMD_CLEAR,  32'h0000_0000, 32'sd0);
        send_word(CMD_LOOKUP, 32'h0000_0405, 32'sd0);
        send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 32'sd0);

        // Random phases. Each phase draws a fresh key pool whose keys share a
        // handful of low buckets, so buckets fill up and replacement gets
        // exercised at every setting; the rest is open keys and noise.
        foreach (phase_bits[p])
        begin
            set_index_bits(phase_bits[p]);
            no_gaps = (p == 2);
            foreach (key_pool[i])
                key_pool[i] = ($urandom() & 32'hFFFF_FC00) | $urandom_range(0, 5);
            repeat (140)
            begin
                r = $urandom_range(0, 99);
                if (r == 0)
                    op = CMD_CLEAR;
                else if (r < 50)
                    op = CMD_INSERT;
                else if (r < 72)
                    op = CMD_LOOKUP;
                else
                    op = CMD_CHECK;

                r = $urandom_range(0, 99);
                if (r < 55)
                    k = key_pool[$urandom_range(0, 15)];
                else if (r < 70)
                    k = last_key;
                else if (r < 80)
                    k = $urandom();
                else if (r < 85)
                    k = '0;
                else if (r < 90)
                    k = '1;
                else
                    k = $urandom_range(0, 15);

                r = $urandom_range(0, 99);
                if (r < 50)
                    s = int'($urandom_range(0, 400)) - 200;
                else if (r < 70)
                    s = $urandom();
                else if (r < 80)
                    s = 32'sh7FFF_FFFF;
                else if (r < 88)
                    s = 32'sh8000_0000;
                else if (r < 95)
                    s = '0;
                else
                    s = ($urandom_range(0, 1) != 0) ? 32'sd1 : -32'sd1;

                send_word(op, k, s);
                last_key = k;
            end
        end
        no_gaps = 1'b0;

        // Drain: drop start, let the checker count the last word as outstanding,
        // wait for every result, then watch a while longer for any stray
        // strobe.
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (fails == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog: far beyond the slowest legal run, including the sweep after
    // reset and every clear walking the whole store
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ bucketed_score_table_core.f @@
sv/bst_pkg.sv
sv/bst_ctrl.sv
sv/bst_dpath.sv
sv/bucketed_score_table_core.sv
sv/bst_checker.sv
tb/score_table_checker.sv
tb/tb_top.sv
